FILE: rtl/srt_pkg.sv
package srt_pkg;

    localparam int CHAR_W     = 8;
    localparam int KEY_W      = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;

    localparam logic [CHAR_W-1:0] PAD_CHAR  = 8'h58;
    localparam logic [KEY_W-1:0]  KEY_RESET = 4'd4;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_FETCH = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_COLUMNS  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DECRYPT_MODE = 1'd1;

    typedef logic [CHAR_W-1:0] t_char;

endpackage

FILE: rtl/srt_in_if.sv
interface srt_in_if import srt_pkg::*; ();

    logic  valid;
    logic  ready;
    logic  req_type;
    t_char char_in;
    logic  last_in;

    modport source (output valid, output req_type, output char_in, output last_in,
                    input ready);
    modport sink (input valid, input req_type, input char_in, input last_in,
                  output ready);

endinterface

FILE: rtl/srt_out_if.sv
interface srt_out_if import srt_pkg::*; ();

    logic  valid;
    logic  ready;
    t_char char_out;
    logic  last_out;
    logic  empty_res;
    logic  overflow;

    modport source (output valid, output char_out, output last_out, output empty_res,
                    output overflow, input ready);
    modport sink (input valid, input char_out, input last_out, input empty_res,
                  input overflow, output ready);

endinterface

FILE: rtl/srt_cfg_if.sv
interface srt_cfg_if import srt_pkg::*; ();

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);

endinterface

FILE: rtl/srt_grid_mem.sv
module srt_grid_mem import srt_pkg::*; #(
    parameter int DEPTH = 576
) (
    input  logic                                        i_clk,
    input  logic                                        i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  t_char                                       i_wr_data,
    input  logic                                        i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output t_char                                       o_rd_data
);

    t_char r_mem [DEPTH];
    t_char r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/srt_spiral_map.sv
module srt_spiral_map import srt_pkg::*; #(
    parameter int ROW_W = 7,
    parameter int COL_W = 4,
    parameter int CNT_W = 10
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [ROW_W-1:0] i_row,
    input  logic [COL_W-1:0] i_col,
    input  logic [ROW_W-1:0] i_rows,
    input  logic [COL_W-1:0] i_cols,
    input  logic [CNT_W-1:0] i_total,
    output logic             o_valid,
    output logic [CNT_W-1:0] o_index
);

    localparam int MW = (CNT_W > ROW_W) ? ((CNT_W > COL_W) ? CNT_W : COL_W)
                                        : ((ROW_W > COL_W) ? ROW_W : COL_W);
    localparam int SW = MW + 2;

    logic [SW-1:0] w_r, w_c, w_rb, w_cb, w_d, w_h, w_w, w_lr, w_lc, w_off;
    logic [SW-1:0] w_prod, w_sum;
    logic [SW-1:0] r_h, r_w, r_off;
    logic          r_valid_a, r_valid_b;
    logic [CNT_W-1:0] r_index;

    // stage A: ring depth, ring size and position along the ring
    always_comb begin
        w_r  = SW'(i_row);
        w_c  = SW'(i_col);
        w_rb = SW'(i_rows) - w_r - 1'b1;
        w_cb = SW'(i_cols) - w_c - 1'b1;
        w_d  = w_r;
        if (w_c < w_d) begin
            w_d = w_c;
        end
        if (w_rb < w_d) begin
            w_d = w_rb;
        end
        if (w_cb < w_d) begin
            w_d = w_cb;
        end
        w_h  = SW'(i_rows) - (w_d << 1);
        w_w  = SW'(i_cols) - (w_d << 1);
        w_lr = w_r - w_d;
        w_lc = w_c - w_d;
        priority if (w_lc == w_w - 1'b1) begin
            w_off = w_lr;
        end else if (w_lr == w_h - 1'b1) begin
            w_off = w_h + w_w - SW'(2) - w_lc;
        end else if (w_lc == '0) begin
            w_off = w_h + w_w - 1'b1 + w_h - SW'(2) - w_lr;
        end else begin
            w_off = (w_h << 1) + w_w - SW'(3) + w_lc;
        end
    end

    // stage B: cells of all outer rings, then the offset on this ring
    assign w_prod = r_h * r_w;
    assign w_sum  = SW'(i_total) - w_prod + r_off;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_a <= 1'b0;
            r_valid_b <= 1'b0;
        end else begin
            r_valid_a <= i_valid;
            r_valid_b <= r_valid_a;
        end
        r_h     <= w_h;
        r_w     <= w_w;
        r_off   <= w_off;
        r_index <= w_sum[CNT_W-1:0];
    end

    assign o_valid = r_valid_b;
    assign o_index = r_index;

endmodule

FILE: rtl/spiral_route_transposition.sv
// Spiral route transposition engine.
// Channels: in_ch carries one request per beat: a load (one character, last_in on
// the final one) or a fetch. Every fetch returns exactly one beat on out_ch; a load
// returns none. cfg_ch writes key_columns (index 0) or decrypt_mode (index 1); any
// write starts a fresh message. Write configuration only while the block is idle.
// Encrypt: characters load row-major, fetches walk the clockwise spiral.
// Decrypt: characters load in spiral order, fetches read row-major and drop 'X'.
// Steps: a load is one write to the grid memory. An encrypt fetch is a memory
// read, then the output register. A decrypt fetch examines grid cells in turn;
// each cell goes through the 2-stage spiral index unit, one memory read and a
// compare. A decrypt scan that runs off the end of the grid, with or without a
// letter in hand, ends with a final check of the scan position. A fetch that
// comes before the message is complete, or after the encrypt output is
// exhausted, goes straight to the output register.
// Reset: key_columns 4, encrypt mode, empty message. The grid memory is not
// cleared; cells past the current message read as padding.
// Stall: a result waits in the output register while the next request is taken;
// a later fetch holds its result until the register frees up.
module spiral_route_transposition import srt_pkg::*; #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 9
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    srt_in_if.sink    in_ch,
    srt_out_if.source out_ch,
    srt_cfg_if.sink   cfg_ch
);

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int ROW_W = $clog2(MAX_ROWS + 1);
    localparam int COL_W = $clog2(MAX_COLS + 1);
    localparam int ADR_W = ROW_W + COL_W + 1;
    localparam int VW    = ((ROW_W > COL_W) ? ROW_W : COL_W) + 2;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_EMPTY    = 3'd1;
    localparam logic [2:0] S_ENC_DATA = 3'd2;
    localparam logic [2:0] S_DEC_MAP  = 3'd3;
    localparam logic [2:0] S_DEC_WAIT = 3'd4;
    localparam logic [2:0] S_DEC_CHK  = 3'd5;
    localparam logic [2:0] S_DEC_OUT  = 3'd6;

    localparam logic [1:0] SIDE_DOWN  = 2'd0;
    localparam logic [1:0] SIDE_LEFT  = 2'd1;
    localparam logic [1:0] SIDE_UP    = 2'd2;
    localparam logic [1:0] SIDE_RIGHT = 2'd3;

    // control and message state
    logic [2:0]       r_state, n_state;
    logic [KEY_W-1:0] r_key, n_key;
    logic             r_decrypt, n_decrypt;
    logic [CNT_W-1:0] r_count, n_count;
    logic [COL_W-1:0] r_load_col, n_load_col;
    logic [ROW_W-1:0] r_rows, n_rows;
    logic [CNT_W-1:0] r_total, n_total;
    logic [ROW_W-1:0] r_ring, n_ring;
    logic [1:0]       r_side, n_side;
    logic [ROW_W-1:0] r_walk_row, n_walk_row;
    logic [COL_W-1:0] r_walk_col, n_walk_col;
    logic [CNT_W-1:0] r_emitted, n_emitted;
    logic             r_complete, n_complete;
    logic             r_ovf, n_ovf;
    logic [ROW_W-1:0] r_scan_row, n_scan_row;
    logic [COL_W-1:0] r_scan_col, n_scan_col;
    logic             r_second, n_second;
    logic             r_out_valid, n_out_valid;

    // payload
    t_char r_ch, n_ch;
    logic  r_last, n_last;
    logic  r_pad, n_pad;
    t_char r_out_char, n_out_char;
    logic  r_out_last, n_out_last;
    logic  r_out_empty, n_out_empty;
    logic  r_out_ovf, n_out_ovf;

    logic             w_cfg_acc, w_in_acc, w_out_free;
    logic [COL_W-1:0] w_cols;
    logic [CNT_W-1:0] w_cap;

    // load bookkeeping
    logic [CNT_W-1:0] w_ld_count_b, w_ld_total_b, w_ld_count, w_ld_total;
    logic [COL_W-1:0] w_ld_col_b, w_ld_col;
    logic [ROW_W-1:0] w_ld_rows_b, w_ld_rows;
    logic             w_ld_fit, w_ld_ovf;

    // encrypt walk
    logic [ADR_W-1:0] w_enc_addr;
    logic             w_enc_pad, w_enc_last;
    logic [VW-1:0]    w_e_d, w_e_r, w_e_c, w_e_wr, w_e_wc, w_e_h, w_e_w, w_e_lr, w_e_lc;
    logic [VW-1:0]    w_e_ring1;
    logic             w_adv_next;
    logic [ROW_W-1:0] w_adv_ring, w_adv_row;
    logic [COL_W-1:0] w_adv_col;
    logic [1:0]       w_adv_side;

    // decrypt scan
    logic [ROW_W-1:0] w_scan_row_nx;
    logic [COL_W-1:0] w_scan_col_nx;
    logic             w_map_valid, w_map_ok;
    logic [CNT_W-1:0] w_map_idx;
    t_char            w_cell;

    // grid memory port
    logic             w_mem_we, w_mem_re;
    logic [AW-1:0]    w_rd_addr;
    t_char            w_rd_data;

    assign w_cfg_acc  = cfg_ch.valid && cfg_ch.ready;
    assign w_in_acc   = in_ch.valid && in_ch.ready;
    assign w_out_free = !r_out_valid || out_ch.ready;

    assign cfg_ch.ready = (r_state == S_IDLE);
    assign in_ch.ready  = (r_state == S_IDLE) && !cfg_ch.valid;

    // effective column count: zero acts as one, clamp at the grid width
    always_comb begin
        priority if (r_key == '0) begin
            w_cols = COL_W'(1);
        end else if (32'(r_key) > MAX_COLS) begin
            w_cols = COL_W'(MAX_COLS);
        end else begin
            w_cols = COL_W'(r_key);
        end
    end

    assign w_cap = CNT_W'(MAX_ROWS * 32'(w_cols));

    // load: a completed message restarts; rows and total grow as rows open
    always_comb begin
        w_ld_count_b = r_complete ? '0 : r_count;
        w_ld_col_b   = r_complete ? '0 : r_load_col;
        w_ld_rows_b  = r_complete ? '0 : r_rows;
        w_ld_total_b = r_complete ? '0 : r_total;
        w_ld_fit     = w_ld_count_b < w_cap;
        w_ld_count   = w_ld_count_b;
        w_ld_col     = w_ld_col_b;
        w_ld_rows    = w_ld_rows_b;
        w_ld_total   = w_ld_total_b;
        w_ld_ovf     = r_complete ? 1'b0 : r_ovf;
        if (w_ld_fit) begin
            w_ld_count = w_ld_count_b + 1'b1;
            if (({1'b0, w_ld_col_b} + 1'b1) == {1'b0, w_cols}) begin
                w_ld_col = '0;
            end else begin
                w_ld_col = w_ld_col_b + 1'b1;
            end
            if (w_ld_col_b == '0) begin
                w_ld_rows  = w_ld_rows_b + 1'b1;
                w_ld_total = w_ld_total_b + CNT_W'(w_cols);
            end
        end else begin
            w_ld_ovf = 1'b1;
        end
    end

    // encrypt read address; cells past the message read as padding
    assign w_enc_addr = ({{(ADR_W-ROW_W){1'b0}}, r_walk_row}
                        * {{(ADR_W-COL_W){1'b0}}, w_cols})
                        + {{(ADR_W-COL_W){1'b0}}, r_walk_col};
    assign w_enc_pad  = w_enc_addr >= {{(ADR_W-CNT_W){1'b0}}, r_count};
    assign w_enc_last = ({1'b0, r_emitted} + 1'b1) >= {1'b0, r_total};

    // one step of the clockwise spiral: down, left, up, right, then next ring in
    always_comb begin
        w_e_d     = VW'(r_ring);
        w_e_r     = VW'(r_rows);
        w_e_c     = VW'(w_cols);
        w_e_wr    = VW'(r_walk_row);
        w_e_wc    = VW'(r_walk_col);
        w_e_h     = w_e_r - (w_e_d << 1);
        w_e_w     = w_e_c - (w_e_d << 1);
        w_e_lr    = w_e_wr - w_e_d;
        w_e_lc    = w_e_wc - w_e_d;
        w_e_ring1 = w_e_d + 1'b1;
        w_adv_next = 1'b0;
        w_adv_ring = r_ring;
        w_adv_side = r_side;
        w_adv_row  = r_walk_row;
        w_adv_col  = r_walk_col;
        if (((w_e_d << 1) >= w_e_r) || ((w_e_d << 1) >= w_e_c)
            || (w_e_wr < w_e_d) || (w_e_wc < w_e_d)) begin
            w_adv_next = 1'b1;
        end else begin
            unique case (r_side)
                SIDE_DOWN: begin
                    if ((w_e_lr + 1'b1) < w_e_h) begin
                        w_adv_row = r_walk_row + 1'b1;
                    end else if (w_e_w > VW'(1)) begin
                        w_adv_side = SIDE_LEFT;
                        w_adv_col  = r_walk_col - 1'b1;
                    end else begin
                        w_adv_next = 1'b1;
                    end
                end
                SIDE_LEFT: begin
                    if (w_e_lc > '0) begin
                        w_adv_col = r_walk_col - 1'b1;
                    end else if (w_e_h > VW'(1)) begin
                        w_adv_side = SIDE_UP;
                        w_adv_row  = r_walk_row - 1'b1;
                    end else begin
                        w_adv_next = 1'b1;
                    end
                end
                SIDE_UP: begin
                    if (w_e_lr > '0) begin
                        w_adv_row = r_walk_row - 1'b1;
                    end else if (w_e_w > VW'(2)) begin
                        w_adv_side = SIDE_RIGHT;
                        w_adv_col  = r_walk_col + 1'b1;
                    end else begin
                        w_adv_next = 1'b1;
                    end
                end
                SIDE_RIGHT: begin
                    if ((w_e_lc + VW'(2)) < w_e_w) begin
                        w_adv_col = r_walk_col + 1'b1;
                    end else begin
                        w_adv_next = 1'b1;
                    end
                end
            endcase
        end
        if (w_adv_next) begin
            w_adv_ring = ROW_W'(w_e_ring1);
            w_adv_side = SIDE_DOWN;
            w_adv_row  = ROW_W'(w_e_ring1);
            if (w_e_ring1 < w_e_c) begin
                w_adv_col = COL_W'(w_e_c - 1'b1 - w_e_ring1);
            end else begin
                w_adv_col = '0;
            end
        end
    end

    // row-major scan position for decrypt
    always_comb begin
        if (({1'b0, r_scan_col} + 1'b1) == {1'b0, w_cols}) begin
            w_scan_row_nx = r_scan_row + 1'b1;
            w_scan_col_nx = '0;
        end else begin
            w_scan_row_nx = r_scan_row;
            w_scan_col_nx = r_scan_col + 1'b1;
        end
    end

    assign w_cell = r_pad ? PAD_CHAR : w_rd_data;

    // main sequencer
    always_comb begin
        n_state     = r_state;
        n_key       = r_key;
        n_decrypt   = r_decrypt;
        n_count     = r_count;
        n_load_col  = r_load_col;
        n_rows      = r_rows;
        n_total     = r_total;
        n_ring      = r_ring;
        n_side      = r_side;
        n_walk_row  = r_walk_row;
        n_walk_col  = r_walk_col;
        n_emitted   = r_emitted;
        n_complete  = r_complete;
        n_ovf       = r_ovf;
        n_scan_row  = r_scan_row;
        n_scan_col  = r_scan_col;
        n_second    = r_second;
        n_ch        = r_ch;
        n_last      = r_last;
        n_pad       = r_pad;
        n_out_valid = r_out_valid && !out_ch.ready;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        n_out_empty = r_out_empty;
        n_out_ovf   = r_out_ovf;
        w_mem_we    = 1'b0;
        w_mem_re    = 1'b0;
        w_map_valid = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (w_cfg_acc) begin
                    if (cfg_ch.index == REG_KEY_COLUMNS) begin
                        n_key = cfg_ch.data;
                    end else if (cfg_ch.index == REG_DECRYPT_MODE) begin
                        n_decrypt = cfg_ch.data[0];
                    end
                    // drop the current message
                    n_count    = '0;
                    n_load_col = '0;
                    n_rows     = '0;
                    n_total    = '0;
                    n_ring     = '0;
                    n_side     = SIDE_DOWN;
                    n_walk_row = '0;
                    n_walk_col = '0;
                    n_emitted  = '0;
                    n_complete = 1'b0;
                    n_ovf      = 1'b0;
                end else if (w_in_acc) begin
                    if (in_ch.req_type == REQ_LOAD) begin
                        w_mem_we   = w_ld_fit;
                        n_count    = w_ld_count;
                        n_load_col = w_ld_col;
                        n_rows     = w_ld_rows;
                        n_total    = w_ld_total;
                        n_ovf      = w_ld_ovf;
                        n_complete = in_ch.last_in;
                        if (r_complete || in_ch.last_in) begin
                            n_ring     = '0;
                            n_side     = SIDE_DOWN;
                            n_emitted  = '0;
                            n_walk_row = '0;
                            n_walk_col = (in_ch.last_in && !r_decrypt)
                                         ? (w_cols - 1'b1) : '0;
                        end
                    end else if (!r_complete) begin
                        n_state = S_EMPTY;
                    end else if (r_decrypt) begin
                        n_scan_row = r_walk_row;
                        n_scan_col = r_walk_col;
                        n_second   = 1'b0;
                        n_state    = S_DEC_MAP;
                    end else if (r_emitted >= r_total) begin
                        n_state = S_EMPTY;
                    end else begin
                        w_mem_re = 1'b1;
                        n_pad    = w_enc_pad;
                        n_state  = S_ENC_DATA;
                    end
                end
            end
            S_EMPTY: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = '0;
                    n_out_last  = 1'b0;
                    n_out_empty = 1'b1;
                    n_out_ovf   = r_ovf;
                    n_state     = S_IDLE;
                end
            end
            S_ENC_DATA: begin
                // hold the read data and the walk until the output register frees
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = w_cell;
                    n_out_last  = w_enc_last;
                    n_out_empty = 1'b0;
                    n_out_ovf   = r_ovf;
                    n_emitted   = r_emitted + 1'b1;
                    if (!w_enc_last) begin
                        n_ring     = w_adv_ring;
                        n_side     = w_adv_side;
                        n_walk_row = w_adv_row;
                        n_walk_col = w_adv_col;
                    end
                    n_state = S_IDLE;
                end
            end
            S_DEC_MAP: begin
                if (r_scan_row >= r_rows) begin
                    if (!r_second) begin
                        n_state = S_EMPTY;
                    end else begin
                        // no letter follows: this one is the last
                        n_walk_row = r_scan_row;
                        n_walk_col = '0;
                        n_last     = 1'b1;
                        n_state    = S_DEC_OUT;
                    end
                end else begin
                    w_map_valid = 1'b1;
                    n_state     = S_DEC_WAIT;
                end
            end
            S_DEC_WAIT: begin
                if (w_map_ok) begin
                    w_mem_re = 1'b1;
                    n_pad    = w_map_idx >= r_count;
                    n_state  = S_DEC_CHK;
                end
            end
            S_DEC_CHK: begin
                if (w_cell == PAD_CHAR) begin
                    n_scan_row = w_scan_row_nx;
                    n_scan_col = w_scan_col_nx;
                    n_state    = S_DEC_MAP;
                end else if (!r_second) begin
                    // found the letter to emit; look ahead for the next one
                    n_ch       = w_cell;
                    n_second   = 1'b1;
                    n_scan_row = w_scan_row_nx;
                    n_scan_col = w_scan_col_nx;
                    n_state    = S_DEC_MAP;
                end else begin
                    n_walk_row = r_scan_row;
                    n_walk_col = r_scan_col;
                    n_last     = 1'b0;
                    n_state    = S_DEC_OUT;
                end
            end
            S_DEC_OUT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = r_ch;
                    n_out_last  = r_last;
                    n_out_empty = 1'b0;
                    n_out_ovf   = r_ovf;
                    n_emitted   = r_emitted + 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_key       <= KEY_RESET;
            r_decrypt   <= 1'b0;
            r_count     <= '0;
            r_load_col  <= '0;
            r_rows      <= '0;
            r_total     <= '0;
            r_ring      <= '0;
            r_side      <= SIDE_DOWN;
            r_walk_row  <= '0;
            r_walk_col  <= '0;
            r_emitted   <= '0;
            r_complete  <= 1'b0;
            r_ovf       <= 1'b0;
            r_scan_row  <= '0;
            r_scan_col  <= '0;
            r_second    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_key       <= n_key;
            r_decrypt   <= n_decrypt;
            r_count     <= n_count;
            r_load_col  <= n_load_col;
            r_rows      <= n_rows;
            r_total     <= n_total;
            r_ring      <= n_ring;
            r_side      <= n_side;
            r_walk_row  <= n_walk_row;
            r_walk_col  <= n_walk_col;
            r_emitted   <= n_emitted;
            r_complete  <= n_complete;
            r_ovf       <= n_ovf;
            r_scan_row  <= n_scan_row;
            r_scan_col  <= n_scan_col;
            r_second    <= n_second;
            r_out_valid <= n_out_valid;
        end
        r_ch        <= n_ch;
        r_last      <= n_last;
        r_pad       <= n_pad;
        r_out_char  <= n_out_char;
        r_out_last  <= n_out_last;
        r_out_empty <= n_out_empty;
        r_out_ovf   <= n_out_ovf;
    end

    // one request at a time: a grid write and a grid read never share a cycle
    assign w_rd_addr = (r_state == S_IDLE) ? w_enc_addr[AW-1:0] : w_map_idx[AW-1:0];

    srt_grid_mem #(
        .DEPTH (DEPTH)
    ) u_grid_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_mem_we),
        .i_wr_addr (w_ld_count_b[AW-1:0]),
        .i_wr_data (in_ch.char_in),
        .i_rd_en   (w_mem_re),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    srt_spiral_map #(
        .ROW_W (ROW_W),
        .COL_W (COL_W),
        .CNT_W (CNT_W)
    ) u_spiral_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_map_valid),
        .i_row   (r_scan_row),
        .i_col   (r_scan_col),
        .i_rows  (r_rows),
        .i_cols  (w_cols),
        .i_total (r_total),
        .o_valid (w_map_ok),
        .o_index (w_map_idx)
    );

    assign out_ch.valid     = r_out_valid;
    assign out_ch.char_out  = r_out_char;
    assign out_ch.last_out  = r_out_last;
    assign out_ch.empty_res = r_out_empty;
    assign out_ch.overflow  = r_out_ovf;

endmodule

FILE: rtl/srt_checker.sv
module srt_checker import srt_pkg::*; (
    input logic  i_clk,
    input logic  i_rst_n,
    input logic  i_in_valid,
    input logic  i_in_ready,
    input logic  i_in_req_type,
    input logic  i_out_valid,
    input logic  i_out_ready,
    input t_char i_char_out,
    input logic  i_last_out,
    input logic  i_empty_res
);

    logic [1:0] r_pending, n_pending;
    logic       w_fetch_acc, w_out_acc;

    assign w_fetch_acc = i_in_valid && i_in_ready && (i_in_req_type == REQ_FETCH);
    assign w_out_acc   = i_out_valid && i_out_ready;

    // fetches taken whose beat has not yet been delivered
    always_comb begin
        n_pending = r_pending;
        if (w_fetch_acc && !w_out_acc) begin
            n_pending = r_pending + 1'b1;
        end else if (!w_fetch_acc && w_out_acc) begin
            n_pending = r_pending - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= n_pending;
        end
    end

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output beat present right after reset");

    a_beat_needs_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (r_pending != 2'd0))
        else $error("output beat without an outstanding fetch");

    a_pending_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= 2'd2)
        else $error("more than two fetches outstanding");

    a_empty_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_empty_res) |-> ((i_char_out == '0) && !i_last_out))
        else $error("empty result carries a character or last flag");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_char_out) && $stable(i_last_out)
             && $stable(i_empty_res)))
        else $error("stalled output beat changed");

endmodule

bind spiral_route_transposition srt_checker u_srt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (in_ch.valid),
    .i_in_ready    (in_ch.ready),
    .i_in_req_type (in_ch.req_type),
    .i_out_valid   (out_ch.valid),
    .i_out_ready   (out_ch.ready),
    .i_char_out    (out_ch.char_out),
    .i_last_out    (out_ch.last_out),
    .i_empty_res   (out_ch.empty_res)
);

FILE: tb/sv/spiral_route_transposition_tb.sv
`timescale 1ns / 1ps

module spiral_route_transposition_tb import srt_pkg::*; ();

    localparam int MAX_ROWS   = 64;
    localparam int MAX_COLS   = 9;
    localparam int GRID_CELLS = MAX_ROWS * MAX_COLS;

    // Let a trailing load finish before a register write, and let the last
    // result drain out before the final verdict.
    localparam int LOAD_SETTLE = 12;
    localparam int END_TAIL    = 20;

    // A decrypt fetch over a grid full of padding scans every cell in turn; the
    // limit must cover that whole scan with nothing moving.
    localparam int WATCHDOG_LIMIT = 20000;

    localparam int RANDOM_BEATS = 680;
    localparam int CALM_FIRST   = 400;
    localparam int CALM_LAST    = 560;

    typedef enum logic [1:0] {
        SIDE_DOWN,
        SIDE_LEFT,
        SIDE_UP,
        SIDE_RIGHT
    } spiral_side_e;

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_REQ
    } row_kind_e;

    typedef struct packed {
        t_char ch;
        logic  last;
        logic  empty;
        logic  ovf;
    } fetch_result_t;

    // One line of the directed table: a register write, or rep request beats.
    // Loads past the first beat of a row carry random characters, and last_in
    // rides on the final beat only.
    typedef struct packed {
        row_kind_e             kind;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        logic                  req;
        t_char                 ch;
        logic                  last;
        logic [9:0]            rep;
        logic                  typed;
        fetch_result_t         want;
    } stim_row_t;

    localparam fetch_result_t EMPTY_OK  = '{8'h00, 1'b0, 1'b1, 1'b0};
    localparam fetch_result_t EMPTY_OVF = '{8'h00, 1'b0, 1'b1, 1'b1};

    localparam int N_DIRECTED = 35;

    logic i_clk;
    logic i_rst_n;

    srt_in_if  in_ch ();
    srt_out_if out_ch ();
    srt_cfg_if cfg_ch ();

    spiral_route_transposition #(
        .MAX_ROWS(MAX_ROWS),
        .MAX_COLS(MAX_COLS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

    // ------------------------------------------------------------------
    // Predictor state: its own copy of the grid, the walk and the registers
    // ------------------------------------------------------------------
    t_char          grid [GRID_CELLS];
    int unsigned    msg_chars;
    int unsigned    msg_rows;
    int unsigned    ring;
    spiral_side_e   side;
    int unsigned    walk_r;
    int unsigned    walk_c;
    int unsigned    emitted;
    logic           msg_done;
    logic           msg_ovf;
    logic [KEY_W-1:0] route_key;
    logic           route_decrypt;

    fetch_result_t  expected_chars [$];
    int             mismatch_count;
    int             beats_sent;
    int             quiet_cycles;

    stim_row_t      directed_rows [N_DIRECTED];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Key 0 behaves as one column, anything past the widest grid as the widest.
    function automatic int unsigned cols_now();
        if (route_key == '0) return 1;
        if (route_key > MAX_COLS) return MAX_COLS;
        return int'(route_key);
    endfunction

    function automatic void clear_message();
        msg_chars = 0;
        msg_rows  = 0;
        ring      = 0;
        side      = SIDE_DOWN;
        walk_r    = 0;
        walk_c    = 0;
        emitted   = 0;
        msg_done  = 1'b0;
        msg_ovf   = 1'b0;
    endfunction

    // Cells past the loaded message read as padding.
    function automatic t_char cell_val(int unsigned s);
        if (s < msg_chars && s < GRID_CELLS) return grid[s];
        return PAD_CHAR;
    endfunction

    // Character at row-major position p, found through its place on the spiral.
    function automatic t_char rowmajor_char(int unsigned p, int unsigned nr,
                                            int unsigned nc);
        int unsigned r, c, d, h, w, lr, lc, base, s;
        r = p / nc;
        c = p % nc;
        d = r;
        if (c < d) d = c;
        if (nr - 1 - r < d) d = nr - 1 - r;
        if (nc - 1 - c < d) d = nc - 1 - c;
        h    = nr - 2 * d;
        w    = nc - 2 * d;
        base = nr * nc - h * w;
        lr   = r - d;
        lc   = c - d;
        if (lc == w - 1)      s = base + lr;
        else if (lr == h - 1) s = base + h + (w - 2 - lc);
        else if (lc == 0)     s = base + h + (w - 1) + (h - 2 - lr);
        else                  s = base + 2 * h + w - 3 + lc;
        return cell_val(s);
    endfunction

    function automatic int unsigned seek_letter(int unsigned p, int unsigned nr,
                                                int unsigned nc);
        while (p < nr * nc && rowmajor_char(p, nr, nc) == PAD_CHAR) p++;
        return p;
    endfunction

    function automatic void next_ring(int unsigned nc);
        ring++;
        side   = SIDE_DOWN;
        walk_r = ring;
        walk_c = (ring < nc) ? nc - 1 - ring : 0;
    endfunction

    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx,
                                      logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_KEY_COLUMNS:  route_key     = val[KEY_W-1:0];
            REG_DECRYPT_MODE: route_decrypt = val[0];
            default: ;
        endcase
        clear_message();
    endfunction

    // Work out what one request beat does; returns 1 when it yields a result.
    function automatic bit predict_transposed(input logic req, input t_char ch,
                                              input logic last_in,
                                              output fetch_result_t res);
        int unsigned nc, nr, total, p, nxt, d, h, w, lr, lc;
        nc  = cols_now();
        res = EMPTY_OK;
        if (req == REQ_LOAD) begin
            if (msg_done) clear_message();
            if (msg_chars < MAX_ROWS * nc && msg_chars < GRID_CELLS) begin
                grid[msg_chars] = ch;
                msg_chars++;
            end else begin
                msg_ovf = 1'b1;
            end
            if (last_in) begin
                msg_done = 1'b1;
                msg_rows = (msg_chars + nc - 1) / nc;
                ring     = 0;
                side     = SIDE_DOWN;
                emitted  = 0;
                walk_r   = 0;
                walk_c   = route_decrypt ? 0 : nc - 1;
            end
            return 1'b0;
        end

        res.ovf = msg_ovf;
        if (!msg_done) return 1'b1;
        nr    = msg_rows;
        total = nr * nc;

        if (route_decrypt) begin
            p = seek_letter(walk_r * nc + walk_c, nr, nc);
            if (p >= total) return 1'b1;
            res.ch   = rowmajor_char(p, nr, nc);
            nxt      = seek_letter(p + 1, nr, nc);
            res.last = (nxt >= total);
            walk_r   = nxt / nc;
            walk_c   = nxt % nc;
            emitted++;
        end else begin
            if (emitted >= total) return 1'b1;
            res.ch = cell_val(walk_r * nc + walk_c);
            emitted++;
            res.last = (emitted >= total);
            if (!res.last) begin
                // Step one cell clockwise around the current ring.
                d = ring;
                if (2 * d >= nr || 2 * d >= nc || walk_r < d || walk_c < d) begin
                    next_ring(nc);
                end else begin
                    h  = nr - 2 * d;
                    w  = nc - 2 * d;
                    lr = walk_r - d;
                    lc = walk_c - d;
                    case (side)
                        SIDE_DOWN: begin
                            if (lr + 1 < h) walk_r++;
                            else if (w > 1) begin
                                side = SIDE_LEFT;
                                walk_c--;
                            end else next_ring(nc);
                        end
                        SIDE_LEFT: begin
                            if (lc > 0) walk_c--;
                            else if (h > 1) begin
                                side = SIDE_UP;
                                walk_r--;
                            end else next_ring(nc);
                        end
                        SIDE_UP: begin
                            if (lr > 0) walk_r--;
                            else if (w > 2) begin
                                side = SIDE_RIGHT;
                                walk_c++;
                            end else next_ring(nc);
                        end
                        default: begin
                            if (lc + 2 < w) walk_c++;
                            else next_ring(nc);
                        end
                    endcase
                end
            end
        end
        res.empty = 1'b0;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Gap roll shared by both sides; hold a calm stretch with no gaps at all.
    function automatic bit take_gap();
        if (beats_sent >= CALM_FIRST && beats_sent < CALM_LAST) return 1'b0;
        return $urandom_range(0, 99) < 21;
    endfunction

    // Mostly letters, padding often, and now and then any byte.
    function automatic t_char rand_char();
        case ($urandom_range(0, 9))
            0, 1:    return PAD_CHAR;
            2:       return t_char'($urandom_range(0, 255));
            default: return t_char'(8'h41 + $urandom_range(0, 25));
        endcase
    endfunction

    // Drive one request beat from the falling edge, hold it until accepted,
    // then queue what it should produce. Valid stays up past the accepting edge
    // until the next call or quiet_in decides at the following falling edge.
    task automatic send_req(input logic req, input t_char ch, input logic last,
                            input logic typed, input fetch_result_t want);
        fetch_result_t res;
        @(negedge i_clk);
        while (take_gap()) begin
            in_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid    = 1'b1;
        in_ch.req_type = req;
        in_ch.char_in  = ch;
        in_ch.last_in  = last;
        do @(posedge i_clk); while (!in_ch.ready);
        beats_sent++;
        if (predict_transposed(req, ch, last, res))
            expected_chars = {expected_chars, (typed ? want : res)};
    endtask

    task automatic quiet_in();
        @(negedge i_clk);
        in_ch.valid = 1'b0;
    endtask

    // Drop the request channel and wait for every outstanding result beat.
    task automatic hold_for_results();
        quiet_in();
        while (expected_chars.size() != 0) @(posedge i_clk);
    endtask

    // Registers change only on an idle block: results drained, loads retired.
    task automatic settle();
        hold_for_results();
        repeat (LOAD_SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        apply_reg(idx, val);
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Result side: random back-pressure, and the scoreboard check
    // ------------------------------------------------------------------
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_ch.ready = !take_gap();
        end
    end

    always @(posedge i_clk) begin
        fetch_result_t want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_chars.size() == 0) begin
                $error("result beat with nothing expected: char_out %02h", out_ch.char_out);
                mismatch_count++;
            end else begin
                want = expected_chars.pop_front();
                if (out_ch.char_out !== want.ch) begin
                    $error("char_out: expected %02h, got %02h", want.ch, out_ch.char_out);
                    mismatch_count++;
                end
                if (out_ch.last_out !== want.last) begin
                    $error("last_out: expected %0b, got %0b", want.last, out_ch.last_out);
                    mismatch_count++;
                end
                if (out_ch.empty_res !== want.empty) begin
                    $error("empty_res: expected %0b, got %0b", want.empty, out_ch.empty_res);
                    mismatch_count++;
                end
                if (out_ch.overflow !== want.ovf) begin
                    $error("overflow: expected %0b, got %0b", want.ovf, out_ch.overflow);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: count cycles in which no channel moves a beat.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        stim_row_t row;
        t_char     ch;
        int        k, len, noise_at, fetch_n, random_end;
        int unsigned nc;
        logic [CFG_DATA_W-1:0] key_val, mode_val;

        // Directed table. Typed expectations only where the answer is plain:
        // empty before the end, empty once exhausted, single-column grids.
        directed_rows = '{
            // Fetch before any message: empty.
            '{ROW_REQ, REG_KEY_COLUMNS, 4'd0, REQ_FETCH, 8'h00, 1'b0, 10'd1, 1'b1, EMPTY_OK},
            // Field extremes on a one-row, four-column grid.
            '{ROW_REQ, REG_KEY_COLUMNS, 4'd0, REQ_LOAD, 8'h41, 1'b0, 10'd1, 1'b0, EMPTY_OK},
            '{ROW_REQ, REG_KEY_COLUMNS, 4'd0, REQ_LOAD, 8'h00, 1'b0, 10'd1, 1'b0, EMPTY_OK},
            '{ROW_REQ, REG_KEY_COLUMNS, 4'd0, REQ_LOAD, 8'hFF, 1'b0, 10'd1, 1'b0, EMPTY_OK},
            '{ROW_REQ, REG_KEY_COLUMNS, 4'd0, REQ_LOAD, 8'h44, 1'b1, 10'd1, 1'b0, EMPTY_OK},
            '{ROW_REQ, REG_KEY_COLUMNS, 4'd0, REQ_FETCH, 8'hFF, 1'b1, 10'd4, 1'b0, EMPTY_OK},
            // Output exhausted: empty again.
            '{ROW_REQ, REG_KEY_COLUMNS, 4'd0, REQ_FETCH, 8'h00, 1'b0, 10'd1, 1'b1, EMPTY_OK},
            // Key 0 acts as one column.
            '{ROW_CFG, REG_KEY_COLUMNS, 4'd0, REQ_LOAD, 8'h00, 1'b0, 10'd1, 1'b0, EMPTY_OK},
            '{ROW_REQ, REG_KEY_COLUMNS, 4'd0, REQ_LOAD, 8'h42, 1'b1, 10'd1, 1'b0, EMPTY_OK},
            '{ROW_REQ, REG_KEY_COLUMNS, 4'd0, REQ_FETCH, 8'h00, 1'b0, 10'd1, 1'b1,
              '{8'h42, 1'b1, 1'b0, 1'b0}},
            '{ROW_REQ, REG_KEY_COLUMNS, 4'd0, REQ_FETCH, 8'h00, 1'b0, 10'd1, 1'b1, EMPTY_OK},
            // Key 15 acts as nine columns; decrypt drops a real letter X.
            '{ROW_CFG, REG_KEY_COLUMNS, 4'd15, REQ_LOAD, 8'h00, 1'b0, 10'd1, 1'b0, EMPTY_OK},
            '{ROW_CFG, REG_DECRYPT_MODE, 4'hF, REQ_LOAD, 8'h00, 1'b0, 10'd1, 1'b0, EMPTY_OK},
            '{ROW_REQ, REG_KEY_COLUMNS, 4'd0, REQ_LOAD, 8'h48, 1'b0, 10'd1, 1'b0, EMPTY_OK},
            '{ROW_REQ, REG_KEY_COLUMNS, 4'd0, REQ_LOAD, 8'h58, 1'b0, 10'd1, 1'b0, EMPTY_OK},
            '{ROW_REQ, REG_KEY_COLUMNS, 4'd0, REQ_LOAD, 8'h49, 1'b1, 10'd1, 1'b0, EMPTY_OK},
            '{ROW_REQ, REG_KEY_COLUMNS, 4'd0, REQ_FETCH, 8'h00, 1'b0, 10'd3, 1'b0, EMPTY_OK},
            // One column, encrypt: overrun the 64-cell grid.
            '{ROW_CFG, REG_KEY_COLUMNS, 4'd1, REQ_LOAD, 8'h00, 1'b0, 10'd1, 1'b0, EMPTY_OK},
            '{ROW_CFG, REG_DECRYPT_MODE, 4'hE, REQ_LOAD, 8'h00, 1'b0, 10'd1, 1'b0, EMPTY_OK},
            '{ROW_REQ, REG_KEY_COLUMNS, 4'd0, REQ_LOAD, 8'h41, 1'b0, 10'd65, 1'b0, EMPTY_OK},
            '{ROW_REQ, REG_KEY_COLUMNS, 4'd0, REQ_FETCH, 8'h00, 1'b0, 10'd1, 1'b1, EMPTY_OVF},
            '{ROW_REQ, REG_KEY_COLUMNS, 4'd0, REQ_LOAD, 8'h5A, 1'b1, 10'd1, 1'b0, EMPTY_OK},
            '{ROW_REQ, REG_KEY_COLUMNS, 4'd0, REQ_FETCH, 8'h00, 1'b0, 10'd2, 1'b0, EMPTY_OK},
            // Load after the end starts over and clears the overflow.
            '{ROW_REQ, REG_KEY_COLUMNS, 4'd0, REQ_LOAD, 8'h51, 1'b1, 10'd1, 1'b0, EMPTY_OK},
            '{ROW_REQ, REG_KEY_COLUMNS, 4'd0, REQ_FETCH, 8'h00, 1'b0, 10'd1, 1'b1,
              '{8'h51, 1'b1, 1'b0, 1'b0}},
            // Widest key, two rows with padding in the tail.
            '{ROW_CFG, REG_KEY_COLUMNS, 4'd9, REQ_LOAD, 8'h00, 1'b0, 10'd1, 1'b0, EMPTY_OK},
            '{ROW_REQ, REG_KEY_COLUMNS, 4'd0, REQ_LOAD, 8'h58, 1'b1, 10'd10, 1'b0, EMPTY_OK},
            '{ROW_REQ, REG_KEY_COLUMNS, 4'd0, REQ_FETCH, 8'h00, 1'b0, 10'd19, 1'b0, EMPTY_OK},
            // Three-column decrypt.
            '{ROW_CFG, REG_KEY_COLUMNS, 4'd3, REQ_LOAD, 8'h00, 1'b0, 10'd1, 1'b0, EMPTY_OK},
            '{ROW_CFG, REG_DECRYPT_MODE, 4'h1, REQ_LOAD, 8'h00, 1'b0, 10'd1, 1'b0, EMPTY_OK},
            '{ROW_REQ, REG_KEY_COLUMNS, 4'd0, REQ_LOAD, 8'h4B, 1'b1, 10'd7, 1'b0, EMPTY_OK},
            '{ROW_REQ, REG_KEY_COLUMNS, 4'd0, REQ_FETCH, 8'h00, 1'b0, 10'd8, 1'b0, EMPTY_OK},
            // A message of padding alone decrypts to nothing.
            '{ROW_REQ, REG_KEY_COLUMNS, 4'd0, REQ_LOAD, 8'h58, 1'b1, 10'd1, 1'b0, EMPTY_OK},
            '{ROW_REQ, REG_KEY_COLUMNS, 4'd0, REQ_FETCH, 8'h00, 1'b0, 10'd1, 1'b1, EMPTY_OK},
            '{ROW_CFG, REG_DECRYPT_MODE, 4'h0, REQ_LOAD, 8'h00, 1'b0, 10'd1, 1'b0, EMPTY_OK}
        };

        // Every input known from time zero; hold reset, then release it at a falling edge.
        i_rst_n         = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.req_type  = REQ_LOAD;
        in_ch.char_in   = '0;
        in_ch.last_in   = 1'b0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = REG_KEY_COLUMNS;
        cfg_ch.data     = '0;
        mismatch_count  = 0;
        beats_sent      = 0;
        quiet_cycles    = 0;
        route_key       = KEY_RESET;
        route_decrypt   = 1'b0;
        clear_message();

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Walk the directed table.
        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            if (row.kind == ROW_CFG) begin
                settle();
                write_reg(row.reg_idx, row.reg_val);
            end else begin
                for (k = 0; k < int'(row.rep); k++) begin
                    ch = (k == 0 || row.req == REQ_FETCH) ? row.ch : rand_char();
                    send_req(row.req, ch, row.last && (k == int'(row.rep) - 1),
                             row.typed, row.want);
                end
            end
        end

        // Random phases: a fresh setting, then a few messages each.
        random_end = beats_sent + RANDOM_BEATS;
        while (beats_sent < random_end) begin
            settle();
            if ($urandom_range(0, 3) == 0) begin
                case ($urandom_range(0, 3))
                    0:       key_val = 4'd0;
                    1:       key_val = 4'd1;
                    2:       key_val = 4'd9;
                    default: key_val = 4'd15;
                endcase
            end else begin
                key_val = CFG_DATA_W'($urandom_range(0, 15));
            end
            // Only bit 0 selects the mode; toggle the rest too.
            mode_val = CFG_DATA_W'($urandom_range(0, 15));
            if ($urandom_range(0, 1) == 1) begin
                write_reg(REG_KEY_COLUMNS, key_val);
                write_reg(REG_DECRYPT_MODE, mode_val);
            end else begin
                write_reg(REG_DECRYPT_MODE, mode_val);
                if ($urandom_range(0, 2) != 0) write_reg(REG_KEY_COLUMNS, key_val);
            end

            repeat ($urandom_range(1, 4)) begin
                nc = cols_now();
                // Mostly short messages; narrow grids now and then run past capacity.
                if (nc <= 2 && $urandom_range(0, 9) == 0)
                    len = $urandom_range(40, MAX_ROWS * nc + 3);
                else
                    len = $urandom_range(1, 3 * nc + 4);
                // Now and then slip a fetch in before the message is complete.
                noise_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, len - 1) : -1;
                for (k = 0; k < len; k++) begin
                    if (k == noise_at)
                        send_req(REQ_FETCH, rand_char(), 1'($urandom_range(0, 1)),
                                 1'b0, EMPTY_OK);
                    send_req(REQ_LOAD, rand_char(), k == len - 1, 1'b0, EMPTY_OK);
                end
                // Usually read everything and a little more; sometimes stop
                // short so the next load cuts the output off.
                if ($urandom_range(0, 5) == 0)
                    fetch_n = $urandom_range(0, len);
                else
                    fetch_n = len + nc + $urandom_range(0, 1);
                repeat (fetch_n)
                    send_req(REQ_FETCH, rand_char(), 1'($urandom_range(0, 1)),
                             1'b0, EMPTY_OK);
                // Hold off the sender until the result side has caught up.
                if ($urandom_range(0, 4) == 0) hold_for_results();
            end
        end

        // Drain, let the tail settle, and report.
        hold_for_results();
        repeat (END_TAIL) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
